>>> rtl/fti_pkg.sv
// ----------------------------------------------------------------------------
// fti_pkg
// Shared widths, register codes, structs and helpers for the fat-tree
// imbalance traffic generator.
// ----------------------------------------------------------------------------
package fti_pkg;

   localparam int MAX_RADIX   = 16;
   localparam int MAX_SERVERS = 1024;
   localparam int MIN_RADIX   = 4;
   localparam int MIN_SERVERS = 16;
   localparam int MIN_PATHS   = 4;
   localparam int MAX_PATHS   = 64;

   localparam int ADDR_W   = 10;
   localparam int RADIX_W  = 5;
   localparam int SERVER_W = 11;
   localparam int PATH_W   = 7;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 11;

   // shared divider: 11-bit dividend, 8-bit divisor
   localparam int DIVD_W = 11;
   localparam int DIVS_W = 8;
   localparam int DCNT_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_RADIX   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SERVERS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PATHS   = 2'd2;

   typedef struct packed {
      logic [RADIX_W-1:0]  radix;
      logic [SERVER_W-1:0] servers;
      logic [PATH_W-1:0]   paths;
   } cfg_type;

   typedef struct packed {
      logic              start;
      logic [DIVD_W-1:0] dividend;
      logic [DIVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIVD_W-1:0] quot;
      logic [DIVS_W-1:0] rem;
   } div_rsp_type;

   // one classified source, handed from front to back
   typedef struct packed {
      logic [ADDR_W-1:0] src;
      logic              ok;
      logic [4:0]        pods;
      logic [4:0]        fpp;
      logic [8:0]        pps;
      logic [3:0]        half;
      logic [7:0]        rpp;
      logic [7:0]        r0;
      logic [9:0]        roff0;
      logic [3:0]        port;
   } job_type;

   typedef struct packed {
      logic [ADDR_W-1:0] src;
      logic [ADDR_W-1:0] dst;
      logic              ok;
      logic              last;
   } result_type;

   function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
      logic [RADIX_W-1:0] e;
      e = r & 5'h1E;
      if (e < RADIX_W'(MIN_RADIX)) e = RADIX_W'(MIN_RADIX);
      else if (e > RADIX_W'(MAX_RADIX & ~1)) e = RADIX_W'(MAX_RADIX & ~1);
      return e;
   endfunction

   function automatic logic [SERVER_W-1:0] eff_servers(input logic [SERVER_W-1:0] s);
      logic [SERVER_W-1:0] e;
      e = s;
      if (e < SERVER_W'(MIN_SERVERS)) e = SERVER_W'(MIN_SERVERS);
      else if (e > SERVER_W'(MAX_SERVERS)) e = SERVER_W'(MAX_SERVERS);
      return e;
   endfunction

   function automatic logic [PATH_W-1:0] eff_paths(input logic [PATH_W-1:0] p);
      logic [PATH_W-1:0] e;
      e = p;
      if (e < PATH_W'(MIN_PATHS)) e = PATH_W'(MIN_PATHS);
      else if (e > PATH_W'(MAX_PATHS)) e = PATH_W'(MAX_PATHS);
      return e;
   endfunction

endpackage

>>> rtl/fti_div.sv
// ----------------------------------------------------------------------------
// fti_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fti_div (
   input  logic                 clock,
   input  logic                 reset,
   input  fti_pkg::div_req_type req,
   output fti_pkg::div_rsp_type rsp
);
   import fti_pkg::*;

   logic [DIVD_W-1:0] quo_ff;
   logic [DIVS_W-1:0] rem_ff;
   logic [DIVS_W-1:0] dvs_ff;
   logic [DCNT_W-1:0] cnt_ff;
   logic              busy_ff;
   logic              done_ff;

   logic [DIVS_W:0]   trial;
   logic [DIVS_W:0]   diff;
   logic              ge;

   assign trial = {rem_ff, quo_ff[DIVD_W-1]};
   assign ge    = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            quo_ff  <= req.dividend;
            rem_ff  <= '0;
            dvs_ff  <= req.divisor;
            cnt_ff  <= DCNT_W'(DIVD_W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            quo_ff <= {quo_ff[DIVD_W-2:0], ge};
            rem_ff <= ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DCNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quo_ff;
   assign rsp.rem  = rem_ff;

endmodule

>>> rtl/fti_front.sv
// ----------------------------------------------------------------------------
// fti_front
// Takes a source address, derives the tree geometry and the source's rack
// position through the shared divider, and queues a job for the back end.
// ----------------------------------------------------------------------------
module fti_front (
   input  logic                     clock,
   input  logic                     reset,
   input  fti_pkg::cfg_type         cfg,
   input  logic                     req_push,
   output logic                     req_full,
   input  logic [fti_pkg::ADDR_W-1:0] req_source_server,
   output fti_pkg::div_req_type     div_req,
   input  fti_pkg::div_rsp_type     div_rsp,
   output logic                     job_push,
   input  logic                     job_full,
   output fti_pkg::job_type         job
);
   import fti_pkg::*;

   typedef enum logic [3:0] {
      F_IDLE, F_PPS, F_FPP, F_RACKS, F_RPP, F_MYRACK, F_MRIP, F_OFFS, F_PUSH
   } state_type;

   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   src_ff;
   logic [8:0]          pps_ff;
   logic [4:0]          fpp_ff;
   logic [7:0]          rpp_ff;
   logic [3:0]          port_ff;
   logic [7:0]          r0_ff;
   logic [9:0]          roff0_ff;
   logic                ok_ff;

   logic [RADIX_W-1:0]  k_eff;
   logic [SERVER_W-1:0] s_eff;
   logic [PATH_W-1:0]   p_eff;
   logic [3:0]          half;
   logic                bad;
   logic [8:0]          r_next;
   logic [11:0]         roff_prod;

   assign k_eff = eff_radix(cfg.radix);
   assign s_eff = eff_servers(cfg.servers);
   assign p_eff = eff_paths(cfg.paths);
   assign half  = k_eff[4:1];

   // rpp comes straight off the divider in F_RPP
   assign bad = ({1'b0, src_ff} >= s_eff) || (div_rsp.quot == '0) || (fpp_ff == '0);

   assign r_next    = {1'b0, div_rsp.rem} + 9'd1;
   assign roff_prod = {4'd0, r0_ff} * {8'd0, half};

   always_comb begin
      state_in         = state_ff;
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = '0;
      unique case (state_ff)
         F_IDLE: begin
            if (req_push) begin
               div_req.start    = 1'b1;
               div_req.dividend = s_eff;
               div_req.divisor  = DIVS_W'(k_eff);
               state_in         = F_PPS;
            end
         end
         F_PPS: begin
            if (div_rsp.done) begin
               div_req.start    = 1'b1;
               div_req.dividend = DIVD_W'(p_eff);
               div_req.divisor  = DIVS_W'(k_eff);
               state_in         = F_FPP;
            end
         end
         F_FPP: begin
            if (div_rsp.done) begin
               div_req.start    = 1'b1;
               div_req.dividend = s_eff;
               div_req.divisor  = DIVS_W'(half);
               state_in         = F_RACKS;
            end
         end
         F_RACKS: begin
            if (div_rsp.done) begin
               div_req.start    = 1'b1;
               div_req.dividend = div_rsp.quot;
               div_req.divisor  = DIVS_W'(k_eff);
               state_in         = F_RPP;
            end
         end
         F_RPP: begin
            if (div_rsp.done) begin
               if (bad) begin
                  state_in = F_PUSH;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = DIVD_W'(src_ff);
                  div_req.divisor  = DIVS_W'(half);
                  state_in         = F_MYRACK;
               end
            end
         end
         F_MYRACK: begin
            if (div_rsp.done) begin
               div_req.start    = 1'b1;
               div_req.dividend = div_rsp.quot;
               div_req.divisor  = rpp_ff;
               state_in         = F_MRIP;
            end
         end
         F_MRIP: begin
            if (div_rsp.done) state_in = F_OFFS;
         end
         F_OFFS:  state_in = F_PUSH;
         F_PUSH: begin
            if (!job_full) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      if (state_ff == F_IDLE && req_push) src_ff <= req_source_server;
      if (div_rsp.done) begin
         unique case (state_ff)
            F_PPS:    pps_ff   <= div_rsp.quot[8:0];
            F_FPP:    fpp_ff   <= div_rsp.quot[4:0];
            F_RPP: begin
               rpp_ff <= div_rsp.quot[7:0];
               ok_ff  <= !bad;
            end
            F_MYRACK: port_ff  <= div_rsp.rem[3:0];
            F_MRIP:   r0_ff <= (r_next == {1'b0, rpp_ff}) ? 8'd0 : r_next[7:0];
            default: ;
         endcase
      end
      if (state_ff == F_OFFS) roff0_ff <= roff_prod[9:0];
   end

   assign req_full = state_ff != F_IDLE;
   assign job_push = state_ff == F_PUSH && !job_full;

   assign job.src   = src_ff;
   assign job.ok    = ok_ff;
   assign job.pods  = k_eff;
   assign job.fpp   = fpp_ff;
   assign job.pps   = pps_ff;
   assign job.half  = half;
   assign job.rpp   = rpp_ff;
   assign job.r0    = r0_ff;
   assign job.roff0 = roff0_ff;
   assign job.port  = port_ff;

endmodule

>>> rtl/fti_job_q.sv
// ----------------------------------------------------------------------------
// fti_job_q
// Two-entry queue of classified jobs between front and back.
// ----------------------------------------------------------------------------
module fti_job_q (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  fti_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output fti_pkg::job_type pop_job,
   output logic             empty
);
   import fti_pkg::*;

   job_type    mem_ff [2];
   logic       wr_ff;
   logic       rd_ff;
   logic [1:0] cnt_ff;

   assign full    = cnt_ff == 2'd2;
   assign empty   = cnt_ff == 2'd0;
   assign pop_job = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop)  rd_ff <= ~rd_ff;
         if (push && !pop)      cnt_ff <= cnt_ff + 2'd1;
         else if (pop && !push) cnt_ff <= cnt_ff - 2'd1;
      end
      if (push) mem_ff[wr_ff] <= push_job;
   end

endmodule

>>> rtl/fti_back.sv
// ----------------------------------------------------------------------------
// fti_back
// Walks pods and rack switches for one job, one destination per cycle while
// the result buffer has room, into a two-entry result buffer.
// ----------------------------------------------------------------------------
module fti_back (
   input  logic                 clock,
   input  logic                 reset,
   input  fti_pkg::job_type     job,
   input  logic                 job_empty,
   output logic                 job_pop,
   output fti_pkg::result_type  rsp,
   output logic                 rsp_empty,
   input  logic                 rsp_pop
);
   import fti_pkg::*;

   typedef enum logic {B_IDLE, B_RUN} state_type;

   state_type  state_ff;
   job_type    cur_ff;
   logic [4:0] pod_ff;
   logic [4:0] flow_ff;
   logic [9:0] base_ff;
   logic [7:0] rack_ff;
   logic [9:0] roff_ff;

   result_type buf_ff [2];
   logic       wr_ff;
   logic       rd_ff;
   logic [1:0] cnt_ff;

   logic       emit;
   logic       last_now;
   logic       flow_end;
   logic       out_pop;
   logic [10:0] dst_sum;
   logic [7:0] rack_inc;
   logic       rack_wrap;
   result_type res;

   assign flow_end  = flow_ff == cur_ff.fpp - 5'd1;
   assign last_now  = !cur_ff.ok || (flow_end && pod_ff == cur_ff.pods - 5'd1);
   assign emit      = state_ff == B_RUN && cnt_ff != 2'd2;
   assign job_pop   = !job_empty && (state_ff == B_IDLE || (emit && last_now));
   assign out_pop   = rsp_pop && cnt_ff != 2'd0;

   assign rack_inc  = rack_ff + 8'd1;
   assign rack_wrap = rack_inc == cur_ff.rpp;
   assign dst_sum   = {1'b0, base_ff} + {1'b0, roff_ff} + {7'd0, cur_ff.port};

   assign res.src  = cur_ff.src;
   assign res.dst  = cur_ff.ok ? dst_sum[ADDR_W-1:0] : '0;
   assign res.ok   = cur_ff.ok;
   assign res.last = last_now;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         if (job_pop) begin
            state_ff <= B_RUN;
         end else if (emit && last_now) begin
            state_ff <= B_IDLE;
         end
         if (emit)    wr_ff <= ~wr_ff;
         if (out_pop) rd_ff <= ~rd_ff;
         if (emit && !out_pop)      cnt_ff <= cnt_ff + 2'd1;
         else if (out_pop && !emit) cnt_ff <= cnt_ff - 2'd1;
      end

      if (emit) buf_ff[wr_ff] <= res;

      if (job_pop) begin
         cur_ff  <= job;
         pod_ff  <= '0;
         flow_ff <= '0;
         base_ff <= '0;
         rack_ff <= job.r0;
         roff_ff <= job.roff0;
      end else if (emit) begin
         if (flow_end) begin
            // next pod restarts at the rack after the source's own
            flow_ff <= '0;
            pod_ff  <= pod_ff + 5'd1;
            base_ff <= base_ff + {1'b0, cur_ff.pps};
            rack_ff <= cur_ff.r0;
            roff_ff <= cur_ff.roff0;
         end else begin
            flow_ff <= flow_ff + 5'd1;
            rack_ff <= rack_wrap ? 8'd0 : rack_inc;
            roff_ff <= rack_wrap ? 10'd0 : roff_ff + {6'd0, cur_ff.half};
         end
      end
   end

   assign rsp       = buf_ff[rd_ff];
   assign rsp_empty = cnt_ff == 2'd0;

endmodule

>>> rtl/fat_tree_imbalance_traffic_gen.sv
// ----------------------------------------------------------------------------
// fat_tree_imbalance_traffic_gen
// For one source server, emits path_count / k destinations in every pod of a
// k-ary fat tree, on the rack switches following the source's rack.
//
// Usage:
//  - req_*: push a source address while req_full is low. The front end holds
//    one address at a time and runs six divisions on a shared bit-serial
//    divider, then queues the job; req_full stays high until the job is queued,
//    and an invalid source stops after four divisions.
//  - rsp_*: results come out of a small queue; the oldest sits on the rsp_
//    ports while rsp_empty is low and leaves on rsp_pop.
//  - The back end produces one result per cycle while its buffer has room:
//    path_count / k rounded down per pod, times k pods (at most 64), or one
//    invalid result. The front end can take a new address while the back end
//    still emits results of earlier jobs; the two ends overlap through a
//    two-entry job queue.
//  - csr_*: writes to switch_radix, server_count, path_count; csr_ready is
//    always high. Write only while the block is idle.
//  - Reset clears all control state; registers return to 4, 16, 4.
//  - When rsp_pop stays low the result buffer fills, the back end stops,
//    then the job queue fills and req_full stays high.
// ----------------------------------------------------------------------------
module fat_tree_imbalance_traffic_gen (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic [fti_pkg::ADDR_W-1:0]     req_source_server,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic [fti_pkg::ADDR_W-1:0]     rsp_source_addr,
   output logic [fti_pkg::ADDR_W-1:0]     rsp_dest_addr,
   output logic                           rsp_addr_valid,
   output logic                           rsp_last_flow,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [fti_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fti_pkg::CSR_DAT_W-1:0]  csr_wdata
);
   import fti_pkg::*;

   cfg_type     cfg_ff;
   div_req_type div_req;
   div_rsp_type div_rsp;
   job_type     front_job;
   job_type     back_job;
   logic        job_push;
   logic        job_full;
   logic        job_pop;
   logic        job_empty;
   result_type  rsp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.radix   <= RADIX_W'(4);
         cfg_ff.servers <= SERVER_W'(16);
         cfg_ff.paths   <= PATH_W'(4);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_RADIX:   cfg_ff.radix   <= csr_wdata[RADIX_W-1:0];
            CSR_SERVERS: cfg_ff.servers <= csr_wdata[SERVER_W-1:0];
            CSR_PATHS:   cfg_ff.paths   <= csr_wdata[PATH_W-1:0];
            default: ;
         endcase
      end
   end

   fti_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   fti_front u_front (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_source_server (req_source_server),
      .div_req           (div_req),
      .div_rsp           (div_rsp),
      .job_push          (job_push),
      .job_full          (job_full),
      .job               (front_job)
   );

   fti_job_q u_job_q (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (front_job),
      .full     (job_full),
      .pop      (job_pop),
      .pop_job  (back_job),
      .empty    (job_empty)
   );

   fti_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job       (back_job),
      .job_empty (job_empty),
      .job_pop   (job_pop),
      .rsp       (rsp),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

   assign rsp_source_addr = rsp.src;
   assign rsp_dest_addr   = rsp.dst;
   assign rsp_addr_valid  = rsp.ok;
   assign rsp_last_flow   = rsp.last;

endmodule

>>> rtl/fti_checker.sv
// ----------------------------------------------------------------------------
// fti_checker
// Port-level checks for the traffic generator, bound to the top level.
// ----------------------------------------------------------------------------
module fti_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_push,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [9:0] rsp_source_addr,
   input logic [9:0] rsp_dest_addr,
   input logic       rsp_addr_valid,
   input logic       rsp_last_flow
);

   // reset leaves the front idle and no result waiting
   a_reset_idle: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("not idle after reset");

   // an invalid source (out of range, or no racks or flows per pod) ends its run at once with a zero destination
   a_invalid_form: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_addr_valid) |-> (rsp_last_flow && rsp_dest_addr == 10'd0))
      else $error("invalid transaction not a single zero result");

   // the address is taken the cycle it is pushed, so full follows
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |=> req_full)
      else $error("front accepted without going busy");

   // a waiting transaction holds until popped
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_dest_addr)
         && $stable(rsp_source_addr) && $stable(rsp_last_flow)))
      else $error("result changed while stalled");

endmodule

bind fat_tree_imbalance_traffic_gen fti_checker u_fti_checker (
   .clock           (clock),
   .reset           (reset),
   .req_push        (req_push),
   .req_full        (req_full),
   .rsp_empty       (rsp_empty),
   .rsp_pop         (rsp_pop),
   .rsp_source_addr (rsp_source_addr),
   .rsp_dest_addr   (rsp_dest_addr),
   .rsp_addr_valid  (rsp_addr_valid),
   .rsp_last_flow   (rsp_last_flow)
);

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fat-tree imbalance traffic generator. A short
// stimulus table covers register extremes, saturation, out-of-range sources
// and degenerate trees. Random phases follow over several register settings
// and idle patterns, including one long result stall. Every popped flow is
// checked against an in-bench model of the destination pattern.
// ----------------------------------------------------------------------------
module tb_top;
   import fti_pkg::*;

   typedef struct packed {
      logic                 cfg;    // 1: register write, 0: source transaction
      logic [CSR_IDX_W-1:0] idx;
      logic [CSR_DAT_W-1:0] value;
      logic [ADDR_W-1:0]    src;
      logic                 bad;    // expect one invalid flow (dest 0, last set)
   } plan_row_type;

   localparam int PLAN_LEN     = 45;
   localparam int PHASES       = 9;
   localparam int PHASE_ITEMS  = 22;
   localparam int HOLD_CYCLES  = 1500;
   localparam int REPORT_LIMIT = 10;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_push = 1'b0;
   logic                 req_full;
   logic [ADDR_W-1:0]    req_source_server = '0;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   logic [ADDR_W-1:0]    rsp_source_addr;
   logic [ADDR_W-1:0]    rsp_dest_addr;
   logic                 rsp_addr_valid;
   logic                 rsp_last_flow;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   fat_tree_imbalance_traffic_gen dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_source_server (req_source_server),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_source_addr   (rsp_source_addr),
      .rsp_dest_addr     (rsp_dest_addr),
      .rsp_addr_valid    (rsp_addr_valid),
      .rsp_last_flow     (rsp_last_flow),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // register copies of the generator
   logic [RADIX_W-1:0]  radix_reg   = RADIX_W'(4);
   logic [SERVER_W-1:0] servers_reg = SERVER_W'(16);
   logic [PATH_W-1:0]   paths_reg   = PATH_W'(4);

   result_type pending_flows[$];
   int         fail_count    = 0;
   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;
   logic       hold_rsp      = 1'b0;
   bit         pressure_go   = 1'b0;

   function automatic plan_row_type item_row(input int src, input bit bad);
      return '{1'b0, CSR_RADIX, CSR_DAT_W'(0), ADDR_W'(src), bad};
   endfunction

   function automatic plan_row_type reg_row(input logic [CSR_IDX_W-1:0] idx, input int value);
      return '{1'b1, idx, CSR_DAT_W'(value), ADDR_W'(0), 1'b0};
   endfunction

   plan_row_type plan [PLAN_LEN] = '{
      // reset values: 4 pods, 16 servers, 4 paths
      item_row(0, 0), item_row(15, 0), item_row(16, 1), item_row(1023, 1),
      // largest tree, 64 flows per source
      reg_row(CSR_RADIX, 16), reg_row(CSR_SERVERS, 1024), reg_row(CSR_PATHS, 64),
      item_row(0, 0), item_row(1023, 0), item_row(517, 0),
      // saturate high
      reg_row(CSR_RADIX, 31), reg_row(CSR_SERVERS, 2047), reg_row(CSR_PATHS, 127),
      item_row(1023, 0), item_row(300, 0),
      // saturate low
      reg_row(CSR_RADIX, 0), reg_row(CSR_SERVERS, 0), reg_row(CSR_PATHS, 0),
      item_row(5, 0), item_row(16, 1),
      // odd radix rounds down, uneven server count
      reg_row(CSR_RADIX, 5), reg_row(CSR_SERVERS, 100), reg_row(CSR_PATHS, 9),
      item_row(99, 0), item_row(100, 1), item_row(37, 0),
      // no rack switches per pod
      reg_row(CSR_RADIX, 16), reg_row(CSR_SERVERS, 16), reg_row(CSR_PATHS, 64),
      item_row(3, 1), item_row(0, 1),
      // no flows per pod
      reg_row(CSR_RADIX, 8), reg_row(CSR_SERVERS, 64), reg_row(CSR_PATHS, 7),
      item_row(10, 1),
      reg_row(CSR_RADIX, 17), reg_row(CSR_SERVERS, 1024), reg_row(CSR_PATHS, 16),
      item_row(777, 0),
      reg_row(CSR_RADIX, 6), reg_row(CSR_SERVERS, 1000), reg_row(CSR_PATHS, 36),
      item_row(999, 0), item_row(1000, 1), item_row(512, 0)
   };

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic int active_servers();
      int s;
      s = servers_reg;
      if (s < MIN_SERVERS) s = MIN_SERVERS;
      else if (s > MAX_SERVERS) s = MAX_SERVERS;
      return s;
   endfunction

   // appends one expected flow at the tail of the queue
   function automatic void add_flow(input result_type r);
      pending_flows.insert(pending_flows.size(), r);
   endfunction

   // queues the flows one source address produces under the current registers
   function automatic void predict_flows(input logic [ADDR_W-1:0] src);
      int k, servers, paths, half, per_pod, fpp, rpp;
      int home_rack, home_in_pod, port, rack, p, f;
      result_type r;
      k = radix_reg & 5'h1E;
      if (k < MIN_RADIX) k = MIN_RADIX;
      else if (k > MAX_RADIX) k = MAX_RADIX;
      servers = active_servers();
      paths = paths_reg;
      if (paths < MIN_PATHS) paths = MIN_PATHS;
      else if (paths > MAX_PATHS) paths = MAX_PATHS;
      half    = k / 2;
      per_pod = servers / k;
      fpp     = paths / k;
      rpp     = (servers / half) / k;
      r.src   = src;
      if (src >= servers || rpp == 0 || fpp == 0) begin
         r.dst  = '0;
         r.ok   = 1'b0;
         r.last = 1'b1;
         add_flow(r);
         return;
      end
      home_rack   = src / half;
      home_in_pod = home_rack % rpp;
      port        = src - home_rack * half;
      for (p = 0; p < k; p++) begin
         for (f = 0; f < fpp; f++) begin
            rack   = (home_in_pod + 1 + f) % rpp;
            r.dst  = ADDR_W'(p * per_pod + rack * half + port);
            r.ok   = 1'b1;
            r.last = (p == k - 1) && (f == fpp - 1);
            add_flow(r);
         end
      end
   endfunction

   // result side: check accepted flows, then pick pop for the next cycle
   always @(posedge clock) begin
      result_type got, want;
      if (!reset && rsp_pop && !rsp_empty) begin
         got = '{rsp_source_addr, rsp_dest_addr, rsp_addr_valid, rsp_last_flow};
         if (pending_flows.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("ERROR %0t: unexpected flow src=%0d dst=%0d ok=%0b last=%0b",
                        $time, got.src, got.dst, got.ok, got.last);
         end else begin
            want = pending_flows.pop_front();
            if (got.src !== want.src || got.dst !== want.dst ||
                got.ok !== want.ok || got.last !== want.last) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT) begin
                  $display("ERROR %0t: expected src=%0d dst=%0d ok=%0b last=%0b",
                           $time, want.src, want.dst, want.ok, want.last);
                  $display("   got src=%0d dst=%0d ok=%0b last=%0b",
                           got.src, got.dst, got.ok, got.last);
               end
            end
         end
      end
      rsp_pop <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);
   end

   // long result stall so the block backs up into req_full
   initial begin
      wait (pressure_go);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_RADIX:   radix_reg = value[RADIX_W-1:0];
         CSR_SERVERS: servers_reg = value[SERVER_W-1:0];
         CSR_PATHS:   paths_reg = value[PATH_W-1:0];
         default: ;
      endcase
   endtask

   task automatic push_source(input logic [ADDR_W-1:0] src, input bit bad);
      result_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push          <= 1'b1;
      req_source_server <= src;
      @(posedge clock);
      while (req_full) @(posedge clock);
      if (bad) begin
         r = '{src, ADDR_W'(0), 1'b0, 1'b1};
         add_flow(r);
      end else begin
         predict_flows(src);
      end
   endtask

   task automatic drain_flows();
      req_push <= 1'b0;
      while (pending_flows.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic run_phase(input int count);
      logic [ADDR_W-1:0] src;
      repeat (count) begin
         if ($urandom_range(99) < 85) src = ADDR_W'($urandom_range(active_servers() - 1));
         else src = ADDR_W'($urandom());
         push_source(src, 1'b0);
      end
   endtask

   initial begin
      int  phase;
      bit  cfg_open;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 16;
      recv_idle_pct = 78;
      cfg_open = 1'b1;
      foreach (plan[i]) begin
         if (plan[i].cfg) begin
            if (!cfg_open) drain_flows();
            cfg_open = 1'b1;
            write_reg(plan[i].idx, plan[i].value);
         end else begin
            if (cfg_open) csr_valid <= 1'b0;
            cfg_open = 1'b0;
            push_source(plan[i].src, plan[i].bad);
         end
      end

      for (phase = 0; phase < PHASES; phase++) begin
         drain_flows();
         case (phase / 3)
            0: begin
               send_idle_pct = 16;
               recv_idle_pct = 78;
            end
            1: begin
               send_idle_pct = 78;
               recv_idle_pct = 16;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         if (phase == 0) begin
            write_reg(CSR_RADIX, CSR_DAT_W'(16));
            write_reg(CSR_SERVERS, CSR_DAT_W'(1024));
            write_reg(CSR_PATHS, CSR_DAT_W'(64));
         end else if (phase == 1) begin
            write_reg(CSR_RADIX, CSR_DAT_W'(4));
            write_reg(CSR_SERVERS, CSR_DAT_W'(16));
            write_reg(CSR_PATHS, CSR_DAT_W'(4));
         end else if (phase == 4) begin
            // raw values, saturation and degenerate trees included
            write_reg(CSR_RADIX, CSR_DAT_W'($urandom_range(31)));
            write_reg(CSR_SERVERS, CSR_DAT_W'($urandom_range(2047)));
            write_reg(CSR_PATHS, CSR_DAT_W'($urandom_range(127)));
         end else begin
            write_reg(CSR_RADIX, CSR_DAT_W'(2 * $urandom_range(8, 2)));
            write_reg(CSR_SERVERS, CSR_DAT_W'($urandom_range(1024, 16)));
            write_reg(CSR_PATHS, CSR_DAT_W'($urandom_range(64, 4)));
         end
         csr_valid <= 1'b0;
         if (phase == 6) pressure_go = 1'b1;
         run_phase(PHASE_ITEMS);
      end

      drain_flows();
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
